// ----- rtl/stt_pkg.sv -----
`timescale 1ns / 1ps

package stt_pkg;

  localparam int NUM_TIMERS = 8;
  localparam int MS_PER_SEC = 1000;

  localparam int OP_W   = 3;
  localparam int IDX_W  = 3;
  localparam int SEC_W  = 16;
  localparam int MS_W   = 10;
  localparam int DLT_W  = 16;
  localparam int STAT_W = 2;

  localparam logic [MS_W-1:0]  MS_RESET          = MS_W'(980);
  localparam logic [SEC_W-1:0] SEC_RESET         = SEC_W'(16'hFFFE);
  localparam logic [SEC_W-1:0] MS_MODE_SEC_LIMIT = SEC_W'(65);

  localparam logic [OP_W-1:0] OP_TICK      = 3'd0;
  localparam logic [OP_W-1:0] OP_START_MS  = 3'd1;
  localparam logic [OP_W-1:0] OP_START_SEC = 3'd2;
  localparam logic [OP_W-1:0] OP_STOP      = 3'd3;
  localparam logic [OP_W-1:0] OP_RESTART   = 3'd4;
  localparam logic [OP_W-1:0] OP_CHECK     = 3'd5;

  localparam logic [STAT_W-1:0] ST_RUNNING  = 2'd0;
  localparam logic [STAT_W-1:0] ST_EXPIRED  = 2'd1;
  localparam logic [STAT_W-1:0] ST_INACTIVE = 2'd2;
  localparam logic [STAT_W-1:0] ST_DONE     = 2'd3;

  typedef struct packed {
    logic [SEC_W-1:0] start_sec;
    logic [MS_W-1:0]  start_ms;
    logic [DLT_W-1:0] delta_sec;
    logic [DLT_W-1:0] delta_msec;
    logic             expired;
  } timer_entry_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              set_expired;
  } chk_res_t;

endpackage

// ----- rtl/stt_timer_check.sv -----
`timescale 1ns / 1ps

module stt_timer_check (
  input  stt_pkg::timer_entry_t      entry_i,
  input  logic [stt_pkg::SEC_W-1:0]  sec_i,
  input  logic [stt_pkg::MS_W-1:0]   ms_i,
  output stt_pkg::chk_res_t          res_o
);
  import stt_pkg::*;

  logic [SEC_W-1:0] sec_diff;
  logic [DLT_W-1:0] ms_prod;
  logic [DLT_W-1:0] ms_elapsed;
  logic             sec_hit;
  logic             ms_hit;

  assign sec_diff = sec_i - entry_i.start_sec;
  // elapsed ms only matters modulo 2^16
  assign ms_prod    = sec_diff * DLT_W'(MS_PER_SEC);
  assign ms_elapsed = ms_prod + DLT_W'(ms_i) - DLT_W'(entry_i.start_ms);

  assign sec_hit = (sec_diff > entry_i.delta_sec) ||
                   ((sec_diff == entry_i.delta_sec) && (ms_i >= entry_i.start_ms));
  assign ms_hit  = (sec_diff > MS_MODE_SEC_LIMIT) || (ms_elapsed >= entry_i.delta_msec);

  always_comb begin
    res_o.status      = ST_RUNNING;
    res_o.set_expired = 1'b0;
    if (entry_i.expired) begin
      res_o.status = ST_EXPIRED;
    end else if (entry_i.delta_sec != '0) begin
      if (sec_hit) begin
        res_o.status      = ST_EXPIRED;
        res_o.set_expired = 1'b1;
      end
    end else if (entry_i.delta_msec != '0) begin
      if (ms_hit) begin
        res_o.status      = ST_EXPIRED;
        res_o.set_expired = 1'b1;
      end
    end else begin
      res_o.status = ST_INACTIVE;
    end
  end

endmodule

// ----- rtl/software_timeout_timer_bank_unit.sv -----
`timescale 1ns / 1ps
// Channel | Handshake               | Payload
// --------+-------------------------+----------------------------------
// in      | in_valid_i / in_stall_o | op_i, timer_index_i, delta_i
// out     | out_valid_o/ out_stall_i| status_o, now_sec_o, now_ms_o
//
// One item per cycle sustained while the output does not stall; an item passes the
// input register, then the timer bank update into the result register.
// The update of the time base and the addressed timer entry happens in the same
// cycle as the item moves into the result register.
// Reset: time base to 980 ms / 65534 s, all timers inactive.
// An output stall holds the result and stalls the input once the input
// register is full.

module software_timeout_timer_bank_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [stt_pkg::OP_W-1:0]    op_i,
  input  logic [stt_pkg::IDX_W-1:0]   timer_index_i,
  input  logic [stt_pkg::DLT_W-1:0]   delta_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [stt_pkg::STAT_W-1:0]  status_o,
  output logic [stt_pkg::SEC_W-1:0]   now_sec_o,
  output logic [stt_pkg::MS_W-1:0]    now_ms_o
);
  import stt_pkg::*;

  logic              in_vld_q, in_vld_d;
  logic [OP_W-1:0]   op_q;
  logic [IDX_W-1:0]  idx_q;
  logic [DLT_W-1:0]  delta_q;
  logic              in_accept;
  logic              proc;

  logic [MS_W-1:0]   ms_q, ms_d;
  logic [SEC_W-1:0]  sec_q, sec_d;
  timer_entry_t      timer_q [NUM_TIMERS];
  timer_entry_t      timer_d [NUM_TIMERS];
  timer_entry_t      entry_sel;
  chk_res_t          chk_res;
  logic              idx_ok;

  logic              res_vld_q;
  logic [STAT_W-1:0] status_q, status_d;
  logic [SEC_W-1:0]  now_sec_q;
  logic [MS_W-1:0]   now_ms_q;

  assign proc       = in_vld_q && (!res_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !proc;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    if (in_accept) begin
      in_vld_d = 1'b1;
    end else if (proc) begin
      in_vld_d = 1'b0;
    end else begin
      in_vld_d = in_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q    <= op_i;
      idx_q   <= timer_index_i;
      delta_q <= delta_i;
    end
  end

  assign idx_ok    = ({1'b0, idx_q} < (IDX_W+1)'(NUM_TIMERS));
  assign entry_sel = timer_q[idx_q];

  stt_timer_check u_check (
    .entry_i (entry_sel),
    .sec_i   (sec_q),
    .ms_i    (ms_q),
    .res_o   (chk_res)
  );

  always_comb begin
    ms_d     = ms_q;
    sec_d    = sec_q;
    timer_d  = timer_q;
    status_d = ST_DONE;
    if (op_q == OP_TICK) begin
      if (({1'b0, ms_q} + 1'b1) >= (MS_W+1)'(MS_PER_SEC)) begin
        ms_d  = '0;
        sec_d = sec_q + 1'b1;
      end else begin
        ms_d = ms_q + 1'b1;
      end
    end else if (op_q <= OP_CHECK) begin
      if (!idx_ok) begin
        status_d = ST_INACTIVE;
      end else begin
        case (op_q)
          OP_START_MS: begin
            timer_d[idx_q].expired    = 1'b0;
            timer_d[idx_q].delta_sec  = '0;
            timer_d[idx_q].delta_msec = delta_q;
            timer_d[idx_q].start_sec  = sec_q;
            timer_d[idx_q].start_ms   = ms_q;
          end
          OP_START_SEC: begin
            timer_d[idx_q].expired    = 1'b0;
            timer_d[idx_q].delta_msec = '0;
            timer_d[idx_q].delta_sec  = delta_q;
            timer_d[idx_q].start_sec  = sec_q;
            timer_d[idx_q].start_ms   = ms_q;
          end
          OP_STOP: begin
            timer_d[idx_q].expired    = 1'b0;
            timer_d[idx_q].delta_sec  = '0;
            timer_d[idx_q].delta_msec = '0;
          end
          OP_RESTART: begin
            timer_d[idx_q].expired = 1'b0;
            if (entry_sel.delta_sec == '0 && entry_sel.delta_msec == '0) begin
              status_d = ST_INACTIVE;
            end else begin
              timer_d[idx_q].start_sec = sec_q;
              timer_d[idx_q].start_ms  = ms_q;
            end
          end
          OP_CHECK: begin
            status_d = chk_res.status;
            if (chk_res.set_expired) begin
              timer_d[idx_q].expired = 1'b1;
            end
          end
          default: begin
            status_d = ST_DONE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ms_q  <= MS_RESET;
      sec_q <= SEC_RESET;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        timer_q[i] <= '0;
      end
    end else if (proc) begin
      ms_q    <= ms_d;
      sec_q   <= sec_d;
      timer_q <= timer_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (proc) begin
      res_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      status_q  <= status_d;
      now_sec_q <= sec_d;
      now_ms_q  <= ms_d;
    end
  end

  assign out_valid_o = res_vld_q;
  assign status_o    = status_q;
  assign now_sec_o   = now_sec_q;
  assign now_ms_o    = now_ms_q;

endmodule
